@@ hw/rtl/circular_deque_assert.svh @@
// Assertion macros shared by the deque RTL; empty when SYNTH is defined.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH
`ifndef SYNTH
// Check on the module's own clk and rst.
`define CDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on an explicitly named clock and reset.
`define CDQ_ASSERT_CLK(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`else
`define CDQ_ASSERT(label, prop, msg)
`define CDQ_ASSERT_CLK(label, ck, rs, prop, msg)
`endif
`endif

@@ hw/rtl/cdq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the circular deque.
package cdq_pkg;

  // Store geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);

  // Command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_REAR   = 3'd3;
  localparam logic [2:0] CMD_DUMP       = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DUMP
  } state_t;

  // Datapath operation for this cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_POP_REAR,
    OP_DUMP_START,
    OP_DUMP_NEXT
  } op_t;

  // Which result the output register loads
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_OK,
    EMIT_FULL,
    EMIT_EMPTY,
    EMIT_MEM
  } emit_t;

  typedef struct packed {
    op_t   op;
    emit_t emit;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic walk_last;
  } stat_t;

endpackage

@@ hw/rtl/circular_deque.sv @@
// Circular double-ended queue of signed 32-bit words, top level.
//
// Requests are taken when start is high and busy is low. Push front, push
// rear, and every refused request (push while full, pop or dump while empty)
// leave busy low, so such requests can follow each other on every clock. A pop
// raises busy while the registered store read completes and the word is handed
// out. A dump raises busy while the single store read port walks from head to
// tail one entry a cycle. Each result is marked by strobe for exactly one
// cycle and is registered, appearing in the cycle after the request or read
// that produced it; the receiver cannot stall it and must take it then.
// result.last marks the final result of a request. Unknown command codes
// produce no result. The store needs no clearing after reset; empty starts
// set.
`timescale 1ns / 1ps
module circular_deque (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  cdq_pkg::req_t  request,
  output logic           strobe,
  output cdq_pkg::rsp_t  result
);

  cdq_pkg::ctrl_t ctrl;
  cdq_pkg::stat_t stat;

  cdq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (request.command),
    .stat    (stat),
    .busy    (busy),
    .ctrl    (ctrl)
  );

  cdq_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .value  (request.value),
    .stat   (stat),
    .strobe (strobe),
    .result (result)
  );

endmodule

@@ hw/rtl/cdq_ctrl.sv @@
`timescale 1ns / 1ps
// Deque controller: decodes requests and sequences pops and dumps.
`include "circular_deque_assert.svh"
module cdq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2:0]          command,
  input  cdq_pkg::stat_t      stat,
  output logic                busy,
  output cdq_pkg::ctrl_t      ctrl
);

  cdq_pkg::state_t state;
  cdq_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cdq_pkg::S_IDLE: begin
        if (start) begin
          case (command)
            cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_REAR: begin
              if (!stat.empty) state_next = cdq_pkg::S_POP;
            end
            cdq_pkg::CMD_DUMP: begin
              if (!stat.empty) state_next = cdq_pkg::S_DUMP;
            end
            default: state_next = cdq_pkg::S_IDLE;
          endcase
        end
      end
      cdq_pkg::S_POP: state_next = cdq_pkg::S_IDLE;
      cdq_pkg::S_DUMP: begin
        if (stat.walk_last) state_next = cdq_pkg::S_IDLE;
      end
      default: state_next = cdq_pkg::S_IDLE;
    endcase
  end

  // Outputs: datapath operation and result selection
  always_comb begin
    ctrl.op   = cdq_pkg::OP_NONE;
    ctrl.emit = cdq_pkg::EMIT_NONE;
    busy      = (state != cdq_pkg::S_IDLE);
    case (state)
      cdq_pkg::S_IDLE: begin
        if (start) begin
          case (command)
            cdq_pkg::CMD_PUSH_FRONT: begin
              if (stat.full) begin
                ctrl.emit = cdq_pkg::EMIT_FULL;
              end else begin
                ctrl.op   = cdq_pkg::OP_PUSH_FRONT;
                ctrl.emit = cdq_pkg::EMIT_OK;
              end
            end
            cdq_pkg::CMD_PUSH_REAR: begin
              if (stat.full) begin
                ctrl.emit = cdq_pkg::EMIT_FULL;
              end else begin
                ctrl.op   = cdq_pkg::OP_PUSH_REAR;
                ctrl.emit = cdq_pkg::EMIT_OK;
              end
            end
            cdq_pkg::CMD_POP_FRONT: begin
              if (stat.empty) ctrl.emit = cdq_pkg::EMIT_EMPTY;
              else            ctrl.op   = cdq_pkg::OP_POP_FRONT;
            end
            cdq_pkg::CMD_POP_REAR: begin
              if (stat.empty) ctrl.emit = cdq_pkg::EMIT_EMPTY;
              else            ctrl.op   = cdq_pkg::OP_POP_REAR;
            end
            cdq_pkg::CMD_DUMP: begin
              if (stat.empty) ctrl.emit = cdq_pkg::EMIT_EMPTY;
              else            ctrl.op   = cdq_pkg::OP_DUMP_START;
            end
            default: ctrl.op = cdq_pkg::OP_NONE;  // unknown code: no result
          endcase
        end
      end
      cdq_pkg::S_POP: ctrl.emit = cdq_pkg::EMIT_MEM;
      cdq_pkg::S_DUMP: begin
        ctrl.emit = cdq_pkg::EMIT_MEM;
        if (!stat.walk_last) ctrl.op = cdq_pkg::OP_DUMP_NEXT;
      end
      default: ctrl.op = cdq_pkg::OP_NONE;
    endcase
  end

  // Checks
  `CDQ_ASSERT_CLK(a_pop_single_cycle, clk, rst, state == cdq_pkg::S_POP |=> state == cdq_pkg::S_IDLE, "pop result took more than one cycle")
  `CDQ_ASSERT(a_dump_goes_busy, start && !busy && command == cdq_pkg::CMD_DUMP && !stat.empty |=> busy, "dump of a non-empty deque did not hold busy")

endmodule

@@ hw/rtl/cdq_dpath.sv @@
`timescale 1ns / 1ps
// Deque datapath: store, head and tail indices, dump walker and result register.
`include "circular_deque_assert.svh"
module cdq_dpath (
  input  logic                clk,
  input  logic                rst,
  input  cdq_pkg::ctrl_t      ctrl,
  input  logic signed [31:0]  value,
  output cdq_pkg::stat_t      stat,
  output logic                strobe,
  output cdq_pkg::rsp_t       result
);

  localparam int IW = cdq_pkg::IDX_W;

  logic signed [31:0] mem [cdq_pkg::DEPTH];
  logic signed [31:0] rd_data;
  logic [IW-1:0]      head;
  logic [IW-1:0]      tail;
  logic [IW-1:0]      walk;
  logic               empty;
  logic               mem_last;   // the word in rd_data ends its request
  logic               full;
  logic               wr_en;
  logic               rd_en;
  logic [IW-1:0]      wr_addr;
  logic [IW-1:0]      rd_addr;

  function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i);
    return (i == IW'(cdq_pkg::DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i);
    return (i == '0) ? IW'(cdq_pkg::DEPTH - 1) : i - 1'b1;
  endfunction

  // Status back to the controller
  assign full = !empty && (idx_next(tail) == head);
  assign stat = '{empty: empty, full: full, walk_last: mem_last};

  // Store addressing
  always_comb begin
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    wr_addr = '0;
    rd_addr = head;
    case (ctrl.op)
      cdq_pkg::OP_PUSH_FRONT: begin
        wr_en   = 1'b1;
        wr_addr = empty ? '0 : idx_prev(head);
      end
      cdq_pkg::OP_PUSH_REAR: begin
        wr_en   = 1'b1;
        wr_addr = empty ? '0 : idx_next(tail);
      end
      cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_DUMP_START: begin
        rd_en   = 1'b1;
        rd_addr = head;
      end
      cdq_pkg::OP_POP_REAR: begin
        rd_en   = 1'b1;
        rd_addr = tail;
      end
      cdq_pkg::OP_DUMP_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = walk;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= value;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Head, tail and empty mark
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      empty <= 1'b1;
    end else begin
      case (ctrl.op)
        cdq_pkg::OP_PUSH_FRONT: begin
          if (empty) begin
            head  <= '0;
            tail  <= '0;
            empty <= 1'b0;
          end else begin
            head <= idx_prev(head);
          end
        end
        cdq_pkg::OP_PUSH_REAR: begin
          if (empty) begin
            head  <= '0;
            tail  <= '0;
            empty <= 1'b0;
          end else begin
            tail <= idx_next(tail);
          end
        end
        cdq_pkg::OP_POP_FRONT: begin
          if (head == tail) empty <= 1'b1;
          else              head  <= idx_next(head);
        end
        cdq_pkg::OP_POP_REAR: begin
          if (head == tail) empty <= 1'b1;
          else              tail  <= idx_prev(tail);
        end
        default: head <= head;
      endcase
    end
  end

  // Dump walker and last mark for the word being read
  always_ff @(posedge clk) begin
    case (ctrl.op)
      cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR: mem_last <= 1'b1;
      cdq_pkg::OP_DUMP_START: begin
        walk     <= idx_next(head);
        mem_last <= (head == tail);
      end
      cdq_pkg::OP_DUMP_NEXT: begin
        walk     <= idx_next(walk);
        mem_last <= (walk == tail);
      end
      default: walk <= walk;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (ctrl.emit != cdq_pkg::EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.emit)
      cdq_pkg::EMIT_OK:    result <= '{status: cdq_pkg::STAT_OK,    data: '0, last: 1'b1};
      cdq_pkg::EMIT_FULL:  result <= '{status: cdq_pkg::STAT_FULL,  data: '0, last: 1'b1};
      cdq_pkg::EMIT_EMPTY: result <= '{status: cdq_pkg::STAT_EMPTY, data: '0, last: 1'b1};
      cdq_pkg::EMIT_MEM:   result <= '{status: cdq_pkg::STAT_OK, data: rd_data, last: mem_last};
      default:             result <= result;
    endcase
  end

  // Checks
  `CDQ_ASSERT(a_not_full_and_empty, !(full && empty), "deque flagged full and empty at once")
  `CDQ_ASSERT(a_refusal_form, strobe && result.status != cdq_pkg::STAT_OK |-> result.data == '0 && result.last, "refused request gave data or missed last")
  `CDQ_ASSERT(a_empty_indices_meet, $rose(empty) |-> head == tail, "deque went empty with head and tail apart")

endmodule

@@ tb/circular_deque_checker.sv @@
`timescale 1ns / 1ps
// Deque checker: shadow model of the store, queue of due results and field comparison.
module circular_deque_checker
  import cdq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t request,
  input  logic strobe,
  input  rsp_t result,
  output int   mismatches,
  output int   outstanding
);

  typedef logic [IDX_W-1:0] slot_t;

  // Shadow copy of the deque
  logic signed [31:0] shadow_words [DEPTH];
  slot_t              head_slot;
  slot_t              tail_slot;
  logic               shadow_empty;

  // Results owed by the block, oldest first
  rsp_t due_results [$];

  function automatic slot_t slot_after(slot_t i);
    return (i == slot_t'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic slot_t slot_before(slot_t i);
    return (i == '0) ? slot_t'(DEPTH - 1) : i - 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR at %0t ns: %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic owe_result(logic [1:0] st, logic signed [31:0] word, logic fin);
    due_results.push_back('{status: st, data: word, last: fin});
  endtask

  // Apply one accepted request to the shadow deque and queue its results
  task automatic apply_command(req_t r);
    slot_t walk;
    logic  full;
    full = !shadow_empty && slot_after(tail_slot) == head_slot;
    case (r.command)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (full) begin
          owe_result(STAT_FULL, '0, 1'b1);
        end else begin
          if (shadow_empty) begin
            // first word always lands in slot zero
            head_slot       = '0;
            tail_slot       = '0;
            shadow_empty    = 1'b0;
            shadow_words[0] = r.value;
          end else if (r.command == CMD_PUSH_FRONT) begin
            head_slot               = slot_before(head_slot);
            shadow_words[head_slot] = r.value;
          end else begin
            tail_slot               = slot_after(tail_slot);
            shadow_words[tail_slot] = r.value;
          end
          owe_result(STAT_OK, '0, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (shadow_empty) begin
          owe_result(STAT_EMPTY, '0, 1'b1);
        end else if (r.command == CMD_POP_FRONT) begin
          owe_result(STAT_OK, shadow_words[head_slot], 1'b1);
          if (head_slot == tail_slot) shadow_empty = 1'b1;
          else head_slot = slot_after(head_slot);
        end else begin
          owe_result(STAT_OK, shadow_words[tail_slot], 1'b1);
          // indices stay put when the last word leaves
          if (head_slot == tail_slot) shadow_empty = 1'b1;
          else tail_slot = slot_before(tail_slot);
        end
      end
      CMD_DUMP: begin
        if (shadow_empty) begin
          owe_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          walk = head_slot;
          for (int n = 0; n < DEPTH; n++) begin
            owe_result(STAT_OK, shadow_words[walk], walk == tail_slot);
            if (walk == tail_slot) break;
            walk = slot_after(walk);
          end
        end
      end
      default: ;  // unknown codes: no result, no change
    endcase
  endtask

  // Results first: a result never belongs to a request taken at the same edge
  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      head_slot    = '0;
      tail_slot    = '0;
      shadow_empty = 1'b1;
      due_results.delete();
    end else begin
      if (strobe !== 1'b0) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with none due", result.data, '0);
        end else begin
          want = due_results.pop_front();
          if (result.status !== want.status)
            report_mismatch("status", 32'(result.status), 32'(want.status));
          if (result.data !== want.data)
            report_mismatch("data", result.data, want.data);
          if (result.last !== want.last)
            report_mismatch("last", 32'(result.last), 32'(want.last));
        end
      end
      if (start && busy === 1'b0) apply_command(request);
    end
    outstanding <= due_results.size();
  end

endmodule

@@ tb/circular_deque_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the circular deque: clock, reset, request stimulus and verdict.
module circular_deque_tb;
  import cdq_pkg::*;

  localparam int RANDOM_ITEMS   = 350;
  localparam int CALM_ITEMS     = 50;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4 * DEPTH;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic strobe;
  rsp_t result;

  int mismatches;
  int outstanding;
  int sent;
  bit gaps_on;

  always #2 clk = ~clk;

  circular_deque dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  circular_deque_checker deque_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .strobe      (strobe),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Extremes turn up often, otherwise any word
  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Present one request and hold it until taken, then maybe idle a while
  task automatic issue(logic [2:0] cmd, logic signed [31:0] val);
    start   <= 1'b1;
    request <= '{command: cmd, value: val};
    do @(posedge clk); while (busy !== 1'b0);
    if (cmd <= CMD_DUMP) sent++;
    if (gaps_on && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
  endtask

  // Hold off until every owed result has come back
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Push past capacity from either end, then dump the full store
  task automatic fill_run();
    repeat (DEPTH + $urandom_range(3, 1))
      issue($urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, rand_word());
    issue(CMD_DUMP, rand_word());
  endtask

  // Maybe dump first, then pop past empty from either end
  task automatic drain_run();
    if ($urandom_range(1)) issue(CMD_DUMP, rand_word());
    repeat (DEPTH + $urandom_range(3, 1))
      issue($urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT, rand_word());
  endtask

  // Any command, with the odd unknown code
  task automatic mixed_run();
    logic [2:0] cmd;
    repeat ($urandom_range(30, 10)) begin
      if ($urandom_range(15) == 0) cmd = 3'($urandom_range(7, 5));
      else cmd = 3'($urandom_range(4));
      issue(cmd, rand_word());
    end
  endtask

  // Watchdog: too long with no request or result taken
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && busy === 1'b0) || strobe === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("FAIL circular_deque");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int kind;
    rst     <= 1'b1;
    start   <= 1'b0;
    request <= '0;
    sent    = 0;
    gaps_on = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: refusals on empty, single word, wrap at the front, extremes
    issue(CMD_DUMP,       rand_word());
    issue(CMD_POP_FRONT,  rand_word());
    issue(CMD_POP_REAR,   rand_word());
    issue(3'd5,           rand_word());
    issue(CMD_PUSH_REAR,  '1);
    issue(CMD_POP_FRONT,  rand_word());
    issue(CMD_PUSH_FRONT, 32'sh8000_0000);
    issue(CMD_PUSH_FRONT, 32'sh7fff_ffff);
    issue(CMD_PUSH_REAR,  '0);
    issue(CMD_DUMP,       rand_word());
    issue(CMD_POP_REAR,   rand_word());
    issue(CMD_POP_FRONT,  rand_word());
    issue(CMD_POP_REAR,   rand_word());
    issue(CMD_POP_REAR,   rand_word());
    issue(3'd6,           rand_word());
    issue(3'd7,           rand_word());
    issue(CMD_PUSH_FRONT, 32'sh5a5a_a5a5);
    issue(CMD_DUMP,       rand_word());
    issue(CMD_POP_REAR,   rand_word());
    wait_for_results();

    // Random: fill and drain runs reach full and empty, mixed runs add noise
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      gaps_on = (sent < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(3) != 0);
      kind    = (phase < 2) ? phase : $urandom_range(2);
      case (kind)
        0:       fill_run();
        1:       drain_run();
        default: mixed_run();
      endcase
      if (gaps_on && $urandom_range(3) == 0) wait_for_results();
      phase++;
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS circular_deque");
    end else begin
      $display("FAIL circular_deque");
    end
    $finish;
  end

endmodule

@@ circular_deque.f @@
+incdir+hw/rtl
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_ctrl.sv
hw/rtl/cdq_dpath.sv
hw/rtl/circular_deque.sv
tb/circular_deque_checker.sv
tb/circular_deque_tb.sv
